>>> sv/sotl_pkg.sv
package sotl_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_BITS_DEF = 32;

    localparam int            CFG_ADDR_BITS = 3;
    localparam logic          REG_PROMOTE_DISTANCE = 1'b0;
    localparam logic [5:0]    PROMOTE_DISTANCE_RESET = 6'd4;

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_REMOVE = 3'd1;
    localparam logic [2:0] CMD_FIND   = 3'd2;
    localparam logic [2:0] CMD_READ   = 3'd3;
    localparam logic [2:0] CMD_SEARCH = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_BAD_INDEX = 2'd3;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] key;
        logic [5:0]  index;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  position;
        logic [31:0] value;
        logic [6:0]  entry_total;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RD_A,
        S_RD_B,
        S_WR_A,
        S_WR_B,
        S_RESP
    } state_t;

endpackage

>>> sv/self_organizing_transpose_list_unit.sv
// Self-organizing key list with a transpose step. Each request beat is one operation:
// insert, remove (swap with the last entry), find or read by index (the entry is swapped
// promote_distance places toward the head, or with the head), or search only; every
// request yields exactly one response beat. The keys live in a single-port synchronous
// memory, and a search reads it one entry per cycle from index 0 until the first match.
// An insert, a bad index or an unused code goes from acceptance to S_RESP and then to the response
// register; a search stays in S_SCAN until a hit or the end of the list, then goes to S_RESP;
// remove adds S_RD_B and S_WR_A after the hit, find adds S_RD_B, S_WR_A and S_WR_B, and read
// by index runs S_RD_A, S_RD_B, S_WR_A and S_WR_B. A new request is taken once the previous
// result sits in the response register, even while that beat is stalled.
module self_organizing_transpose_list_unit #(
    parameter int CAPACITY = sotl_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = sotl_pkg::KEY_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  sotl_pkg::req_t                     req,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output sotl_pkg::rsp_t                     rsp,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sotl_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [KEY_BITS-1:0] mem [CAPACITY];
    logic [KEY_BITS-1:0] rdata_reg;

    logic                mem_rd_en;
    logic [AW-1:0]       mem_rd_addr;
    logic                mem_wr_en;
    logic [AW-1:0]       mem_wr_addr;
    logic [KEY_BITS-1:0] mem_wr_data;

    sotl_pkg::state_t    state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [5:0]          dist_reg, dist_next;
    logic [2:0]          cmd_reg, cmd_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [AW-1:0]       p_reg, p_next;
    logic [KEY_BITS-1:0] a_reg, a_next;
    logic [1:0]          status_reg, status_next;
    logic [CW-1:0]       scan_reg, scan_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0]       cmp_idx_reg, cmp_idx_next;
    sotl_pkg::rsp_t      rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic [KEY_BITS-1:0] key_in;
    logic [AW-1:0]       q_val;
    logic                cfg_wr;

    assign key_in    = KEY_BITS'(req.key);
    assign req_stall = (state_reg != sotl_pkg::S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite
                       && (paddr[sotl_pkg::CFG_ADDR_BITS-1:2] == sotl_pkg::REG_PROMOTE_DISTANCE);

    always_comb
    begin
        if (paddr[sotl_pkg::CFG_ADDR_BITS-1:2] == sotl_pkg::REG_PROMOTE_DISTANCE)
        begin
            prdata = {26'd0, dist_reg};
        end
        else
        begin
            prdata = 32'd0;
        end
    end

    // The swap partner: the last entry for a remove, otherwise the promotion target.
    always_comb
    begin
        if (cmd_reg == sotl_pkg::CMD_REMOVE)
        begin
            q_val = AW'(count_reg - CW'(1));
        end
        else if (32'(p_reg) < 32'(dist_reg))
        begin
            q_val = '0;
        end
        else
        begin
            q_val = AW'(32'(p_reg) - 32'(dist_reg));
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        dist_next      = cfg_wr ? pwdata[5:0] : dist_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        p_next         = p_reg;
        a_next         = a_reg;
        status_next    = status_reg;
        scan_next      = scan_reg;
        cmp_vld_next   = cmp_vld_reg;
        cmp_idx_next   = cmp_idx_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = '0;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = '0;
        mem_wr_data    = '0;

        unique case (state_reg)
            sotl_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next     = req.cmd;
                    key_next     = key_in;
                    status_next  = sotl_pkg::ST_OK;
                    p_next       = '0;
                    scan_next    = '0;
                    cmp_vld_next = 1'b0;
                    unique case (req.cmd)
                        sotl_pkg::CMD_INSERT:
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                status_next = sotl_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = AW'(count_reg);
                                mem_wr_data = key_in;
                                p_next      = AW'(count_reg);
                                count_next  = count_reg + CW'(1);
                            end
                            state_next = sotl_pkg::S_RESP;
                        end
                        sotl_pkg::CMD_REMOVE, sotl_pkg::CMD_FIND, sotl_pkg::CMD_SEARCH:
                        begin
                            state_next = sotl_pkg::S_SCAN;
                        end
                        sotl_pkg::CMD_READ:
                        begin
                            if (32'(req.index) >= 32'(count_reg))
                            begin
                                status_next = sotl_pkg::ST_BAD_INDEX;
                                state_next  = sotl_pkg::S_RESP;
                            end
                            else
                            begin
                                p_next     = AW'(req.index);
                                state_next = sotl_pkg::S_RD_A;
                            end
                        end
                        default:
                        begin
                            state_next = sotl_pkg::S_RESP;
                        end
                    endcase
                end
            end

            sotl_pkg::S_SCAN:
            begin
                if (cmp_vld_reg && (rdata_reg == key_reg))
                begin
                    p_next       = cmp_idx_reg;
                    cmp_vld_next = 1'b0;
                    state_next   = (cmd_reg == sotl_pkg::CMD_SEARCH) ? sotl_pkg::S_RESP
                                                                     : sotl_pkg::S_RD_B;
                end
                else if (scan_reg < count_reg)
                begin
                    mem_rd_en    = 1'b1;
                    mem_rd_addr  = AW'(scan_reg);
                    cmp_idx_next = AW'(scan_reg);
                    cmp_vld_next = 1'b1;
                    scan_next    = scan_reg + CW'(1);
                end
                else
                begin
                    cmp_vld_next = 1'b0;
                    status_next  = sotl_pkg::ST_NOT_FOUND;
                    p_next       = '0;
                    state_next   = sotl_pkg::S_RESP;
                end
            end

            sotl_pkg::S_RD_A:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = p_reg;
                state_next  = sotl_pkg::S_RD_B;
            end

            sotl_pkg::S_RD_B:
            begin
                a_next      = rdata_reg;
                mem_rd_en   = 1'b1;
                mem_rd_addr = q_val;
                state_next  = sotl_pkg::S_WR_A;
            end

            sotl_pkg::S_WR_A:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = p_reg;
                mem_wr_data = rdata_reg;
                if (cmd_reg == sotl_pkg::CMD_REMOVE)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = sotl_pkg::S_RESP;
                end
                else
                begin
                    state_next = sotl_pkg::S_WR_B;
                end
            end

            sotl_pkg::S_WR_B:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = q_val;
                mem_wr_data = a_reg;
                p_next      = q_val;
                state_next  = sotl_pkg::S_RESP;
            end

            sotl_pkg::S_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.status      = status_reg;
                    rsp_next.position    = 6'(p_reg);
                    rsp_next.entry_total = 7'(count_reg);
                    if ((status_reg == sotl_pkg::ST_OK)
                        && ((cmd_reg == sotl_pkg::CMD_FIND) || (cmd_reg == sotl_pkg::CMD_READ)))
                    begin
                        rsp_next.value = 32'(a_reg);
                    end
                    else
                    begin
                        rsp_next.value = 32'd0;
                    end
                    rsp_valid_next = 1'b1;
                    state_next     = sotl_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = sotl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            rdata_reg <= mem[mem_rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sotl_pkg::S_IDLE;
            count_reg     <= '0;
            dist_reg      <= sotl_pkg::PROMOTE_DISTANCE_RESET;
            cmp_vld_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dist_reg      <= dist_next;
            cmp_vld_reg   <= cmp_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        key_reg     <= key_next;
        p_reg       <= p_next;
        a_reg       <= a_next;
        status_reg  <= status_next;
        scan_reg    <= scan_next;
        cmp_idx_reg <= cmp_idx_next;
        rsp_reg     <= rsp_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_write_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> (32'(mem_wr_addr) <= 32'(count_reg)))
        else $error("write beyond the end of the list");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && (req.cmd == sotl_pkg::CMD_INSERT)
         && (count_reg != CW'(CAPACITY)))
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the list");

    a_rsp_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == sotl_pkg::S_RESP))
        else $error("response beat raised outside the response state");

endmodule
